// File: sv/emba_pkg.sv
// ----------------------------------------------------------------------------
// emba_pkg
// Shared codes and widths for the extent map block allocator.
// ----------------------------------------------------------------------------
package emba_pkg;

  localparam int unsigned LBW = 24;
  localparam int unsigned PBW = 16;
  localparam int unsigned CNTW = 17;
  localparam int unsigned CFGW = 17;

  typedef enum logic [1:0] {
    FUNC_LOOKUP = 2'd0,
    FUNC_MAP    = 2'd1,
    FUNC_CONS   = 2'd2,
    FUNC_CLEAR  = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_HIT   = 3'd0,
    ST_HOLE  = 3'd1,
    ST_NEW   = 3'd2,
    ST_NOFREE = 3'd3,
    ST_FULL  = 3'd4
  } status_e;

  localparam logic CFG_TOTAL = 1'b0;
  localparam logic CFG_RESERVED = 1'b1;

endpackage

// File: sv/extent_map_block_allocator_core.sv
// ----------------------------------------------------------------------------
// extent_map_block_allocator_core
// Extent table of one file plus a bitmap block allocator held in a memory.
// ----------------------------------------------------------------------------
// Channel  | Direction | Handshake                   | Payload
// in       | input     | in_valid_i / in_stall_o     | func_i, file_blk_i
// out      | output    | out_valid_o / out_stall_i   | disk_blk_o, status_o, merged_o,
//          |           |                             | avail_cnt_o
// cfg      | input     | cfg_we_i                    | cfg_index_i, cfg_data_i
//
// Lookup searches one slot per cycle. Clear answers in the cycle after the word
// is taken. Consolidate visits one slot pair per cycle. Map-for-write on a
// miss adds a bitmap scan that reads and checks each 32-bit word in turn from
// the reserved word onward, and then places the block: first it tries to
// extend an adjacent extent, then it takes an empty slot.
// After reset a clearing pass zeroes the bitmap word by word and no word is
// accepted meanwhile. A waiting result holds the block busy, and after each
// accepted result the block returns to idle, where the next word is taken.
module extent_map_block_allocator_core
  import emba_pkg::*;
#(
  parameter int unsigned NUM_BLOCKS = 65536,
  parameter int unsigned EXTENT_SLOTS = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [1:0]      func_i,
  input  logic [LBW-1:0]  file_blk_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [PBW-1:0]  disk_blk_o,
  output logic [2:0]      status_o,
  output logic            merged_o,
  output logic [CNTW-1:0] avail_cnt_o,
  input  logic            cfg_we_i,
  input  logic            cfg_index_i,
  input  logic [CFGW-1:0] cfg_data_i
);

  localparam int unsigned WORDS = (NUM_BLOCKS + 31) / 32;
  localparam int unsigned AW = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned BW = $clog2(NUM_BLOCKS) + 1;
  localparam int unsigned SW = $clog2(EXTENT_SLOTS);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_FIND, S_SCAN, S_CHECK, S_PADJ, S_PEMPTY,
    S_CONS, S_OUT
  } state_e;

  state_e state_q;
  logic [AW-1:0]  init_q;
  logic [CFGW-1:0] total_q, reserved_q;
  logic [CNTW-1:0] alloc_q;
  logic [LBW-1:0] els_q [EXTENT_SLOTS];
  logic [PBW-1:0] eps_q [EXTENT_SLOTS];
  logic [CNTW-1:0] elen_q [EXTENT_SLOTS];
  logic [1:0]     func_q;
  logic [LBW-1:0] lb_q;
  logic [SW-1:0]  i_q, j_q;
  logic [BW-1:0]  blk_q;
  logic [PBW-1:0] pb_q;
  logic [2:0]     st_q;
  logic           merged_q, rd_pend_q;

  // Bitmap memory with registered read.
  logic [31:0] mem [WORDS];
  logic        mem_we;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [31:0] mem_wd, mem_rd_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_rd_q <= mem[mem_ra];
  end

  // Effective limits.
  logic [BW-1:0] lim, res;
  logic [CNTW:0] usable;
  always_comb begin
    lim = (32'(total_q) > NUM_BLOCKS) ? BW'(NUM_BLOCKS) : BW'(total_q);
    res = (reserved_q == '0) ? BW'(1) :
          ((32'(reserved_q) > NUM_BLOCKS) ? BW'(NUM_BLOCKS) : BW'(reserved_q));
  end
  logic [BW-1:0] usable_b;
  assign usable_b = (lim > res) ? lim - res : '0;
  assign usable = (CNTW+1)'(usable_b);
  logic [CNTW-1:0] free_now;
  assign free_now = (usable > {1'b0, alloc_q}) ? CNTW'(usable - {1'b0, alloc_q}) : '0;

  // Single-slot compares for the current slot index.
  logic [LBW-1:0] off;
  logic hit_i, adj_i;
  always_comb begin
    off = lb_q - els_q[i_q];
    hit_i = (elen_q[i_q] != '0) && (lb_q >= els_q[i_q]) &&
            (off < {7'b0, elen_q[i_q]});
    adj_i = (elen_q[i_q] != '0) &&
            ((32'(els_q[i_q]) + 32'(elen_q[i_q])) == 32'(lb_q)) &&
            ((32'(eps_q[i_q]) + 32'(elen_q[i_q])) == 32'(blk_q));
  end

  // Lowest free bit in the read word at or above the current block.
  logic [31:0] freemask;
  logic        found;
  logic [4:0]  fbit;
  always_comb begin
    freemask = ~mem_rd_q & ({32{1'b1}} << blk_q[4:0]);
    found = 1'b0;
    fbit = '0;
    for (int k = 31; k >= 0; k--) begin
      if (freemask[k]) begin
        found = 1'b1;
        fbit = 5'(k);
      end
    end
  end
  logic [BW-1:0] cand;
  assign cand = {blk_q[BW-1:5], fbit};

  logic cons_hit;
  assign cons_hit = (elen_q[i_q] != '0) && (elen_q[j_q] != '0) &&
    ((32'(els_q[i_q]) + 32'(elen_q[i_q])) == 32'(els_q[j_q])) &&
    ((32'(eps_q[i_q]) + 32'(elen_q[i_q])) == 32'(eps_q[j_q]));

  always_comb begin
    mem_we = 1'b0;
    mem_wa = blk_q[AW+4:5];
    mem_wd = mem_rd_q | (32'b1 << cand[4:0]);
    mem_ra = blk_q[AW+4:5];
    if (state_q == S_INIT) begin
      mem_we = 1'b1;
      mem_wa = init_q;
      mem_wd = '0;
    end else if (state_q == S_SCAN && !rd_pend_q && found && cand < lim) begin
      mem_we = 1'b1;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign disk_blk_o = pb_q;
  assign status_o = st_q;
  assign merged_o = merged_q;
  assign avail_cnt_o = free_now;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      init_q <= '0;
      total_q <= CFGW'(65536);
      reserved_q <= CFGW'(1);
      alloc_q <= '0;
      rd_pend_q <= 1'b0;
      func_q <= FUNC_LOOKUP;
      lb_q <= '0;
      i_q <= '0;
      j_q <= '0;
      blk_q <= '0;
      pb_q <= '0;
      st_q <= ST_HIT;
      merged_q <= 1'b0;
      for (int k = 0; k < EXTENT_SLOTS; k++) begin
        els_q[k] <= '0;
        eps_q[k] <= '0;
        elen_q[k] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_TOTAL) total_q <= cfg_data_i;
        else reserved_q <= cfg_data_i;
      end
      case (state_q)
        S_INIT: begin
          init_q <= init_q + AW'(1);
          if (32'(init_q) == WORDS - 1) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid_i) begin
            func_q <= func_i;
            lb_q <= file_blk_i;
            i_q <= '0;
            j_q <= SW'(1);
            pb_q <= '0;
            st_q <= ST_HIT;
            merged_q <= 1'b0;
            case (func_e'(func_i))
              FUNC_LOOKUP, FUNC_MAP: state_q <= S_FIND;
              FUNC_CONS: state_q <= S_CONS;
              default: begin
                for (int k = 0; k < EXTENT_SLOTS; k++) begin
                  els_q[k] <= '0;
                  eps_q[k] <= '0;
                  elen_q[k] <= '0;
                end
                state_q <= S_OUT;
              end
            endcase
          end
        end
        S_FIND: begin
          if (hit_i) begin
            pb_q <= eps_q[i_q] + off[PBW-1:0];
            state_q <= S_OUT;
          end else if (32'(i_q) == EXTENT_SLOTS - 1) begin
            if (func_q == FUNC_LOOKUP) begin
              st_q <= ST_HOLE;
              state_q <= S_OUT;
            end else if (res >= lim) begin
              st_q <= ST_NOFREE;
              state_q <= S_OUT;
            end else begin
              blk_q <= res;
              rd_pend_q <= 1'b1;
              state_q <= S_SCAN;
            end
          end else begin
            i_q <= i_q + SW'(1);
          end
        end
        S_SCAN: begin
          if (rd_pend_q) begin
            rd_pend_q <= 1'b0;
          end else if (found && cand < lim) begin
            blk_q <= cand;
            alloc_q <= alloc_q + CNTW'(1);
            i_q <= '0;
            state_q <= S_PADJ;
          end else if ({blk_q[BW-1:5], 5'b0} + BW'(32) >= lim) begin
            st_q <= ST_NOFREE;
            state_q <= S_OUT;
          end else begin
            blk_q <= {blk_q[BW-1:5] + (BW-5)'(1), 5'b0};
            rd_pend_q <= 1'b1;
          end
        end
        S_PADJ: begin
          if (adj_i) begin
            elen_q[i_q] <= elen_q[i_q] + CNTW'(1);
            pb_q <= blk_q[PBW-1:0];
            st_q <= ST_NEW;
            state_q <= S_OUT;
          end else if (32'(i_q) == EXTENT_SLOTS - 1) begin
            i_q <= '0;
            state_q <= S_PEMPTY;
          end else begin
            i_q <= i_q + SW'(1);
          end
        end
        S_PEMPTY: begin
          if (elen_q[i_q] == '0) begin
            els_q[i_q] <= lb_q;
            eps_q[i_q] <= blk_q[PBW-1:0];
            elen_q[i_q] <= CNTW'(1);
            pb_q <= blk_q[PBW-1:0];
            st_q <= ST_NEW;
            state_q <= S_OUT;
          end else if (32'(i_q) == EXTENT_SLOTS - 1) begin
            st_q <= ST_FULL;
            state_q <= S_OUT;
          end else begin
            i_q <= i_q + SW'(1);
          end
        end
        S_CONS: begin
          if (cons_hit) begin
            elen_q[i_q] <= elen_q[i_q] + elen_q[j_q];
            elen_q[j_q] <= '0;
            els_q[j_q] <= '0;
            eps_q[j_q] <= '0;
            merged_q <= 1'b1;
          end
          if (32'(j_q) == EXTENT_SLOTS - 1) begin
            if (32'(i_q) == EXTENT_SLOTS - 2) begin
              state_q <= S_OUT;
            end else begin
              i_q <= i_q + SW'(1);
              j_q <= i_q + SW'(2);
            end
          end else begin
            j_q <= j_q + SW'(1);
          end
        end
        S_OUT: begin
          if (!out_stall_i) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
